>>> rtl/vcf_pkg.sv
// Shared types and constants for the vertical complementary filter.
package vcf_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input action codes
    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_FIX     = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME     = 3'd0,
        REG_STEP_RATE     = 3'd1,
        REG_GAIN_HEIGHT   = 3'd2,
        REG_GAIN_VELOCITY = 3'd3,
        REG_GAIN_BIAS     = 3'd4
    } vcf_reg_t;

    localparam logic [CFG_W-1:0] RST_STEP_TIME     = 16'd328;
    localparam logic [CFG_W-1:0] RST_STEP_RATE     = 16'd200;
    localparam logic [CFG_W-1:0] RST_GAIN_HEIGHT   = 16'd3840;
    localparam logic [CFG_W-1:0] RST_GAIN_VELOCITY = 16'd128;
    localparam logic [CFG_W-1:0] RST_GAIN_BIAS     = 16'd51;

    typedef struct packed {
        logic [CFG_W-1:0] step_time;
        logic [CFG_W-1:0] step_rate;
        logic [CFG_W-1:0] gain_height;
        logic [CFG_W-1:0] gain_velocity;
        logic [CFG_W-1:0] gain_bias;
    } vcf_cfg_t;

    // Classified request: fix or predict, with the one sample it needs
    typedef struct packed {
        logic              fix;
        logic              armed;
        logic [DATA_W-1:0] value;
    } vcf_cmd_t;

endpackage

>>> rtl/vcf_front.sv
// Front end: accept input requests and classify them into queue commands.
module vcf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic signed [vcf_pkg::DATA_W-1:0] accel,
    input  logic signed [vcf_pkg::DATA_W-1:0] altitude,
    input  logic                         armed,
    input  logic                         q_full,
    output logic                         push,
    output vcf_pkg::vcf_cmd_t            cmd
);
    import vcf_pkg::*;

    logic     hold_reg;
    logic     hold_next;
    vcf_cmd_t cmd_reg;
    vcf_cmd_t cmd_next;
    logic     accept;

    // Stall only when a held command cannot drain into the queue
    assign in_stall = hold_reg && q_full;
    assign push     = hold_reg && !q_full;
    assign accept   = in_valid && !in_stall;
    assign cmd      = cmd_reg;

    always_comb
    begin
        hold_next = accept || in_stall;
        cmd_next  = cmd_reg;
        if (accept)
        begin
            cmd_next.fix   = (action == ACT_FIX);
            cmd_next.armed = armed;
            cmd_next.value = (action == ACT_FIX) ? altitude : accel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

>>> rtl/vcf_queue.sv
// Short command queue between the front end and the arithmetic back end.
module vcf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vcf_pkg::vcf_cmd_t cmd_in,
    output logic              full,
    output logic              valid,
    output vcf_pkg::vcf_cmd_t cmd_out,
    input  logic              pop
);
    import vcf_pkg::*;

    vcf_cmd_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign cmd_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> rtl/vcf_back.sv
// Back end: multiply sequencer that runs the predict and fix updates.
module vcf_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vcf_pkg::vcf_cfg_t                 cfg,
    input  logic                              q_valid,
    input  vcf_pkg::vcf_cmd_t                 q_cmd,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [vcf_pkg::DATA_W-1:0] velocity,
    output logic signed [vcf_pkg::DATA_W-1:0] height
);
    import vcf_pkg::*;

    localparam int MUL_W  = 33;
    localparam int MULB_W = CFG_W + 1;
    localparam int PROD_W = MUL_W + MULB_W;
    localparam int OPA_W  = 49;
    localparam int SPLIT  = 24;
    localparam int ACC_W  = 66;
    localparam int EXT_W  = ACC_W + 1;
    localparam int REF_W  = 26;
    localparam int BIAS_W = 23;
    localparam int CORR_W = 41;
    localparam int BFV_W  = 42;

    localparam logic signed [EXT_W-1:0] MAX32    = 67'sd2147483647;
    localparam logic signed [EXT_W-1:0] MIN32    = -67'sd2147483648;
    localparam logic signed [EXT_W-1:0] LIM_REF  = 67'sd32768000;
    localparam logic signed [EXT_W-1:0] LIM_BIAS = 67'sd3276800;
    localparam logic signed [EXT_W-1:0] LIM_BT   = 67'sd140737488355328;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_FIN, S_OUT} state_t;
    typedef enum logic [3:0] {
        OP_PV, OP_PH, OP_REF, OP_FH, OP_FV, OP_BT, OP_BA, OP_H, OP_V
    } op_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [EXT_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > MAX32)
        begin
            r = MAX32[DATA_W-1:0];
        end
        else if (x < MIN32)
        begin
            r = MIN32[DATA_W-1:0];
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [EXT_W-1:0] clamp(input logic signed [EXT_W-1:0] x,
                                                      input logic signed [EXT_W-1:0] lim);
        logic signed [EXT_W-1:0] r;
        if (x > lim)
        begin
            r = lim;
        end
        else if (x < -lim)
        begin
            r = -lim;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic                      hi_reg, hi_next;
    vcf_cmd_t                  cmd_reg, cmd_next;
    logic signed [OPA_W-1:0]   opa_reg, opa_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DATA_W-1:0]  vel_reg, vel_next;
    logic signed [DATA_W-1:0]  hgt_reg, hgt_next;
    logic signed [BIAS_W-1:0]  bias_reg, bias_next;
    logic signed [DATA_W-1:0]  prev_reg, prev_next;
    logic                      pend_reg, pend_next;
    logic signed [REF_W-1:0]   ref_reg, ref_next;
    logic signed [CORR_W-1:0]  fh_reg, fh_next;
    logic signed [CORR_W-1:0]  fv_reg, fv_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  velocity_reg, velocity_next;
    logic signed [DATA_W-1:0]  height_reg, height_next;

    logic                      is_wide;
    logic                      chain;
    logic signed [MUL_W-1:0]   mul_a;
    logic [CFG_W-1:0]          mul_b_u;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]   r8, r16, r24;
    logic signed [EXT_W-1:0]   v_sum, h_sum, b_sum;
    logic signed [EXT_W-1:0]   ref_full, bt_full, bias_full;
    logic signed [DATA_W-1:0]  v_sat, h_sat;
    logic signed [DATA_W-1:0]  cmd_value, q_value;
    logic signed [MUL_W-1:0]   alt_h, ref_v, diff_q;
    logic signed [BFV_W-1:0]   bias_fv;

    assign is_wide = (op_reg == OP_BT) || (op_reg == OP_BA) || (op_reg == OP_H)
                     || (op_reg == OP_V);
    assign chain   = is_wide && !hi_reg;

    // Wide operands go through the multiplier as a signed upper and unsigned lower half
    always_comb
    begin
        if (!is_wide)
        begin
            mul_a = opa_reg[MUL_W-1:0];
        end
        else if (hi_reg)
        begin
            mul_a = MUL_W'($signed(opa_reg[OPA_W-1:SPLIT]));
        end
        else
        begin
            mul_a = $signed({{(MUL_W-SPLIT){1'b0}}, opa_reg[SPLIT-1:0]});
        end
    end

    always_comb
    begin
        unique case (op_reg) inside
            OP_REF:  mul_b_u = cfg.step_rate;
            OP_FH:   mul_b_u = cfg.gain_height;
            OP_FV:   mul_b_u = cfg.gain_velocity;
            OP_BT:   mul_b_u = cfg.gain_bias;
            OP_PV, OP_PH, OP_BA, OP_H, OP_V: mul_b_u = cfg.step_time;
            default: mul_b_u = cfg.step_time;
        endcase
    end

    assign mul_b = $signed({1'b0, mul_b_u});

    // Round to nearest, ties upward
    assign r8  = (acc_reg + ACC_W'(128)) >>> 8;
    assign r16 = (acc_reg + ACC_W'(32768)) >>> 16;
    assign r24 = (acc_reg + ACC_W'(8388608)) >>> 24;

    assign v_sum     = EXT_W'(vel_reg) + EXT_W'(r16);
    assign h_sum     = EXT_W'(hgt_reg) + EXT_W'(r16);
    assign b_sum     = EXT_W'(bias_reg) + EXT_W'(r24);
    assign v_sat     = sat32(v_sum);
    assign h_sat     = sat32(h_sum);
    assign ref_full  = clamp(-EXT_W'(acc_reg), LIM_REF);
    assign bt_full   = clamp(EXT_W'(acc_reg), LIM_BT);
    assign bias_full = clamp(b_sum, LIM_BIAS);

    assign cmd_value = $signed(cmd_reg.value);
    assign q_value   = $signed(q_cmd.value);
    assign alt_h     = MUL_W'(cmd_value) - MUL_W'(hgt_reg);
    assign ref_v     = MUL_W'(ref_reg) - MUL_W'(vel_reg);
    assign diff_q    = MUL_W'(q_value) - MUL_W'(prev_reg);
    assign bias_fv   = BFV_W'(bias_reg) + BFV_W'(fv_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        hi_next        = hi_reg;
        cmd_next       = cmd_reg;
        opa_next       = opa_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        vel_next       = vel_reg;
        hgt_next       = hgt_reg;
        bias_next      = bias_reg;
        prev_next      = prev_reg;
        pend_next      = pend_reg;
        ref_next       = ref_reg;
        fh_next        = fh_reg;
        fv_next        = fv_reg;
        out_valid_next = out_valid_reg;
        velocity_next  = velocity_reg;
        height_next    = height_reg;
        pop            = 1'b0;

        // Drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = q_cmd;
                    hi_next    = 1'b0;
                    state_next = S_MUL;
                    if (q_cmd.fix)
                    begin
                        op_next  = OP_REF;
                        opa_next = OPA_W'(diff_q);
                    end
                    else
                    begin
                        op_next  = OP_PV;
                        opa_next = OPA_W'(q_value);
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = (chain ? (acc_reg <<< SPLIT) : ACC_W'(0)) + ACC_W'(prod_reg);
                if (is_wide && hi_reg)
                begin
                    hi_next    = 1'b0;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_MUL;
                hi_next    = 1'b0;
                unique case (op_reg)
                    OP_PV:
                    begin
                        vel_next = v_sat;
                        opa_next = OPA_W'(v_sat);
                        op_next  = OP_PH;
                    end
                    OP_PH:
                    begin
                        hgt_next   = h_sat;
                        state_next = S_OUT;
                    end
                    OP_REF:
                    begin
                        ref_next  = $signed(ref_full[REF_W-1:0]);
                        prev_next = cmd_value;
                        opa_next  = OPA_W'(alt_h);
                        op_next   = OP_FH;
                    end
                    OP_FH:
                    begin
                        fh_next  = $signed(r8[CORR_W-1:0]);
                        opa_next = OPA_W'(ref_v);
                        op_next  = OP_FV;
                    end
                    OP_FV:
                    begin
                        fv_next  = $signed(r8[CORR_W-1:0]);
                        opa_next = OPA_W'($signed(r8[CORR_W-1:0]));
                        op_next  = OP_BT;
                        hi_next  = 1'b1;
                    end
                    OP_BT:
                    begin
                        opa_next = $signed(bt_full[OPA_W-1:0]);
                        op_next  = OP_BA;
                        hi_next  = 1'b1;
                    end
                    OP_BA:
                    begin
                        bias_next = $signed(bias_full[BIAS_W-1:0]);
                        opa_next  = OPA_W'(fh_reg);
                        op_next   = OP_H;
                        hi_next   = 1'b1;
                    end
                    OP_H:
                    begin
                        hgt_next = h_sat;
                        opa_next = OPA_W'(bias_fv);
                        op_next  = OP_V;
                        hi_next  = 1'b1;
                    end
                    OP_V:
                    begin
                        vel_next   = v_sat;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    velocity_next  = vel_reg;
                    height_next    = hgt_reg;
                    if (cmd_reg.fix)
                    begin
                        if (pend_reg || !cmd_reg.armed)
                        begin
                            hgt_next = '0;
                        end
                        pend_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PV;
            hi_reg        <= 1'b0;
            cmd_reg       <= '0;
            opa_reg       <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            vel_reg       <= '0;
            hgt_reg       <= '0;
            bias_reg      <= '0;
            prev_reg      <= '0;
            pend_reg      <= 1'b1;
            ref_reg       <= '0;
            fh_reg        <= '0;
            fv_reg        <= '0;
            out_valid_reg <= 1'b0;
            velocity_reg  <= '0;
            height_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            hi_reg        <= hi_next;
            cmd_reg       <= cmd_next;
            opa_reg       <= opa_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            vel_reg       <= vel_next;
            hgt_reg       <= hgt_next;
            bias_reg      <= bias_next;
            prev_reg      <= prev_next;
            pend_reg      <= pend_next;
            ref_reg       <= ref_next;
            fh_reg        <= fh_next;
            fv_reg        <= fv_next;
            out_valid_reg <= out_valid_next;
            velocity_reg  <= velocity_next;
            height_reg    <= height_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign velocity  = velocity_reg;
    assign height    = height_reg;

endmodule

>>> rtl/vertical_complementary_filter.sv
// Top level of the vertical complementary filter: config registers and the datapath.
// The back end finishes one request before it pops the next; the single shared
// 33x17 multiplier in the back end sequences every product, two passes for wide ones.
// Reset: rst_n (async, active low) clears estimates, bias and previous altitude,
//   sets the reset-pending flag and loads the register defaults. No clearing pass.
module vertical_complementary_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic signed [vcf_pkg::DATA_W-1:0]    accel,
    input  logic signed [vcf_pkg::DATA_W-1:0]    altitude,
    input  logic                                 armed,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [vcf_pkg::DATA_W-1:0]    velocity,
    output logic signed [vcf_pkg::DATA_W-1:0]    height,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vcf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vcf_pkg::CFG_W-1:0]            cfg_data
);
    import vcf_pkg::*;

    vcf_cfg_t cfg_reg;
    vcf_cfg_t cfg_next;
    logic     cfg_write;

    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_valid;
    vcf_cmd_t front_cmd;
    vcf_cmd_t q_cmd;

    // Configuration must only be written while the filter is idle (not enforced here), so always take it.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Decode the register index; unknown indexes leave everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (vcf_reg_t'(cfg_index))
                REG_STEP_TIME:     cfg_next.step_time     = cfg_data;
                REG_STEP_RATE:     cfg_next.step_rate     = cfg_data;
                REG_GAIN_HEIGHT:   cfg_next.gain_height   = cfg_data;
                REG_GAIN_VELOCITY: cfg_next.gain_velocity = cfg_data;
                REG_GAIN_BIAS:     cfg_next.gain_bias     = cfg_data;
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_time     <= RST_STEP_TIME;
            cfg_reg.step_rate     <= RST_STEP_RATE;
            cfg_reg.gain_height   <= RST_GAIN_HEIGHT;
            cfg_reg.gain_velocity <= RST_GAIN_VELOCITY;
            cfg_reg.gain_bias     <= RST_GAIN_BIAS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: hold one request, tag it as predict or fix, push it on.
    vcf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .accel    (accel),
        .altitude (altitude),
        .armed    (armed),
        .q_full   (q_full),
        .push     (push),
        .cmd      (front_cmd)
    );

    // Two-entry queue lets the front keep taking requests while the back end
    // grinds through a fix or waits on a stalled result.
    vcf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .full    (q_full),
        .valid   (q_valid),
        .cmd_out (q_cmd),
        .pop     (pop)
    );

    // Back end: sequenced multiply/round/saturate steps over the filter state,
    // with the result held in an output register.
    vcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .velocity  (velocity),
        .height    (height)
    );

    // The back end never takes a command from an empty queue.
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("back end popped an empty command queue");

    // A full queue always offers a command to the back end.
    a_full_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_valid)
        else $error("queue reports full without a valid entry");

    // The input side only stalls when the queue is backed up.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("input stalled while the queue had room");

endmodule

>>> verif/tb_vertical_complementary_filter.sv
// Self-checking regression bench for the vertical complementary filter.
`timescale 1ns / 1ps

module tb_vertical_complementary_filter;

    import vcf_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int MAX_IDLE        = 16;
    localparam int SETTLE_CYCLES   = 40;        // settle margin after the last owed estimate
    localparam int HOLD_CYCLES     = 400;       // long receiver hold-off to back up the queue
    localparam int LIMIT_CYCLES    = 600000;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    localparam longint REF_LIMIT   = 500 * 65536;
    localparam longint BIAS_LIMIT  = 50 * 65536;
    localparam longint BTERM_LIMIT = longint'(1) << 47;

    typedef struct packed {
        logic signed [DATA_W-1:0] velocity;
        logic signed [DATA_W-1:0] height;
    } estimate_t;

    // One directed request; typed rows carry an expectation written by hand.
    typedef struct packed {
        logic                     act;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] alt;
        logic                     arm;
        logic                     typed;
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] hgt;
    } request_row_t;

    // DUT ports; the driven inputs are known from time zero
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     action    = ACT_PREDICT;
    logic signed [DATA_W-1:0] accel     = '0;
    logic signed [DATA_W-1:0] altitude  = '0;
    logic                     armed     = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] height;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data  = '0;

    // Mirror of the filter: registers and estimator state
    vcf_cfg_t cfg_mirror;
    int       est_vel;
    int       est_hgt;
    int       bias_acc;
    int       prev_alt;
    bit       clear_pending;

    // Estimates the block still owes, oldest first
    estimate_t pending_estimates [$];

    // Pacing controls: no_idle for sender and receiver, hold_request for the receiver
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    int walk_alt      = 0;
    int n_errors      = 0;
    int n_checked     = 0;
    int n_predict     = 0;
    int n_fix         = 0;
    int n_disarmed    = 0;
    int n_holds       = 0;
    int unsigned cycle_count = 0;

    // Directed requests: opening state, field extremes, armed ignored on predict,
    // reference clamp both ways, disarmed fix, small climbs and descents.
    request_row_t directed_rows [14] = '{
        // estimates stay at zero right after reset
        '{ACT_PREDICT, 32'sd0, 32'sd0, 1'b0, 1'b1, 32'sd0, 32'sd0},
        // level barometer on the first fix: nothing moves, pending clear taken
        '{ACT_FIX, 32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0},
        '{ACT_PREDICT, WORD_MAX, WORD_MIN, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{ACT_PREDICT, WORD_MIN, WORD_MAX, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{ACT_PREDICT, 32'sd1, 32'sd0, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{ACT_PREDICT, -32'sd1, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{ACT_FIX, 32'sd0, WORD_MAX, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{ACT_FIX, 32'sd0, WORD_MIN, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{ACT_FIX, 32'sd0, WORD_MIN, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{ACT_FIX, WORD_MAX, 32'sh0001_0000, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{ACT_FIX, 32'sd0, 32'sh0002_0000, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{ACT_PREDICT, 32'sh03e8_0000, 32'sd0, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{ACT_PREDICT, 32'shfc18_0000, 32'sd0, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{ACT_FIX, 32'sd0, -32'sd1, 1'b1, 1'b0, 32'sd0, 32'sd0}
    };

    vertical_complementary_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .accel     (accel),
        .altitude  (altitude),
        .armed     (armed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .velocity  (velocity),
        .height    (height),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Round to nearest, ties toward plus infinity: floor((x + half) / 2^s)
    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint limit_mag(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    function automatic int sat_word(input longint x);
        if (x > longint'(WORD_MAX))
            return WORD_MAX;
        if (x < longint'(WORD_MIN))
            return WORD_MIN;
        return int'(x);
    endfunction

    // Advance the mirrored estimator by one request and return what the block reports.
    function automatic estimate_t advance_filter(input logic act,
                                                 input logic signed [DATA_W-1:0] acc,
                                                 input logic signed [DATA_W-1:0] alt,
                                                 input logic arm);
        longint    st;
        longint    rt;
        longint    ref_vel;
        longint    fh;
        longint    fv;
        longint    bterm;
        estimate_t report;
        st = cfg_mirror.step_time;
        rt = cfg_mirror.step_rate;
        if (act == ACT_PREDICT)
        begin
            // Integrate acceleration, then the fresh velocity; armed plays no part.
            est_vel = sat_word(longint'(est_vel) + round_shift(longint'(acc) * st, 16));
            est_hgt = sat_word(longint'(est_hgt) + round_shift(longint'(est_vel) * st, 16));
            report  = {est_vel, est_hgt};
        end
        else
        begin
            ref_vel  = limit_mag(-(longint'(alt) - longint'(prev_alt)) * rt, REF_LIMIT);
            prev_alt = alt;
            fh       = round_shift(longint'(cfg_mirror.gain_height)
                                   * (longint'(alt) - longint'(est_hgt)), 8);
            fv       = round_shift(longint'(cfg_mirror.gain_velocity)
                                   * (ref_vel - longint'(est_vel)), 8);
            bterm    = limit_mag(longint'(cfg_mirror.gain_bias) * fv, BTERM_LIMIT);
            bias_acc = int'(limit_mag(longint'(bias_acc) + round_shift(bterm * st, 24),
                                      BIAS_LIMIT));
            est_hgt  = sat_word(longint'(est_hgt) + round_shift(fh * st, 16));
            est_vel  = sat_word(longint'(est_vel)
                                + round_shift((longint'(bias_acc) + fv) * st, 16));
            report   = {est_vel, est_hgt};
            // Clear height after reporting; velocity, bias and last altitude survive.
            if (clear_pending || !arm)
            begin
                est_hgt       = 0;
                clear_pending = 1'b0;
            end
        end
        return report;
    endfunction

    function automatic logic signed [DATA_W-1:0] noise_word();
        case ($urandom_range(0, 4))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            default: return $urandom();
        endcase
    endfunction

    // Offer one request after a drawn gap, hold it until taken, then record
    // the estimate it owes (the hand-written one where the row gives it).
    task automatic offer_request(input logic act,
                                 input logic signed [DATA_W-1:0] acc,
                                 input logic signed [DATA_W-1:0] alt,
                                 input logic arm,
                                 input bit typed,
                                 input estimate_t typed_est);
        int        gap;
        estimate_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        accel    <= acc;
        altitude <= alt;
        armed    <= arm;
        do @(posedge clk); while (in_stall);
        predicted = advance_filter(act, acc, alt, arm);
        pending_estimates.push_back(typed ? typed_est : predicted);
        if (act == ACT_PREDICT)
            n_predict++;
        else
        begin
            n_fix++;
            if (!arm)
                n_disarmed++;
        end
    endtask

    // Hold one register write until taken; valid stays up for back-to-back writes.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_STEP_TIME:     cfg_mirror.step_time     = data;
            REG_STEP_RATE:     cfg_mirror.step_rate     = data;
            REG_GAIN_HEIGHT:   cfg_mirror.gain_height   = data;
            REG_GAIN_VELOCITY: cfg_mirror.gain_velocity = data;
            REG_GAIN_BIAS:     cfg_mirror.gain_bias     = data;
            default:           ;    // unmapped index: the block drops it
        endcase
    endtask

    task automatic program_registers(input vcf_cfg_t setting, input bit stray);
        write_register(REG_STEP_TIME, setting.step_time);
        write_register(REG_STEP_RATE, setting.step_rate);
        if (stray)
            write_register(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                                     int'(REG_GAIN_BIAS) + 1)),
                           CFG_W'($urandom()));
        write_register(REG_GAIN_HEIGHT, setting.gain_height);
        write_register(REG_GAIN_VELOCITY, setting.gain_velocity);
        write_register(REG_GAIN_BIAS, setting.gain_bias);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every owed estimate, then let the pipeline settle.
    task automatic drain_filter();
        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result sink: stall a drawn number of cycles before each result, or hold off
    // for a long stretch when asked so the block fills and stalls its input.
    initial
    begin : result_sink
        int pause;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                n_holds++;
            end
            else
            begin
                pause = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
                if (pause != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (pause) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each taken result with the oldest owed estimate.
    always @(posedge clk)
    begin : result_check
        estimate_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_estimates.size() == 0)
            begin
                $display("%0t: unexpected result, velocity %0d height %0d",
                         $time, velocity, height);
                n_errors++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                n_checked++;
                if (velocity !== want.velocity)
                begin
                    $display("%0t: velocity expected %0d, got %0d",
                             $time, want.velocity, velocity);
                    n_errors++;
                end
                if (height !== want.height)
                begin
                    $display("%0t: height expected %0d, got %0d",
                             $time, want.height, height);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: stop a hung run well past the slowest legal one.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d estimates still owed",
                     $time, pending_estimates.size());
            $display("vertical_complementary_filter regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                       phase;
        int                       item;
        vcf_cfg_t                 setting;
        logic                     act;
        logic                     arm;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] alt;

        // Mirror the reset state of the block.
        cfg_mirror    = '{RST_STEP_TIME, RST_STEP_RATE, RST_GAIN_HEIGHT,
                          RST_GAIN_VELOCITY, RST_GAIN_BIAS};
        est_vel       = 0;
        est_hgt       = 0;
        bias_acc      = 0;
        prev_alt      = 0;
        clear_pending = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset register values
        foreach (directed_rows[r])
            offer_request(directed_rows[r].act, directed_rows[r].acc, directed_rows[r].alt,
                          directed_rows[r].arm, directed_rows[r].typed,
                          {directed_rows[r].vel, directed_rows[r].hgt});

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                drain_filter();
                // Walk through the register extremes, a random setting, then back home.
                case (phase)
                    1:
                    begin
                        setting = '1;
                    end
                    2:
                    begin
                        setting = '0;      // zero step time and rate: nothing integrates, height can still clear
                    end
                    3:
                    begin
                        setting           = '1;
                        setting.step_time = 16'd1;
                        setting.step_rate = 16'd1;
                    end
                    4:
                    begin
                        setting.step_time     = CFG_W'($urandom_range(1, 16'hffff));
                        setting.step_rate     = CFG_W'($urandom_range(1, 16'hffff));
                        setting.gain_height   = CFG_W'($urandom());
                        setting.gain_velocity = CFG_W'($urandom());
                        setting.gain_bias     = CFG_W'($urandom());
                    end
                    default:
                    begin
                        setting = '{RST_STEP_TIME, RST_STEP_RATE, RST_GAIN_HEIGHT,
                                    RST_GAIN_VELOCITY, RST_GAIN_BIAS};
                    end
                endcase
                program_registers(setting, phase == 4);
            end

            // Open the first random phase with a long hold-off and a back-to-back sender.
            no_idle = (phase == 0);
            if (phase == 0)
                hold_request = 1'b1;

            for (item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                if (item % 32 == 31)
                    no_idle = ($urandom_range(0, 3) == 0);
                arm = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 9) < 7)
                begin
                    // Plausible flight: small accelerations, a fix every few requests,
                    // barometer wandering smoothly.
                    act      = ($urandom_range(0, 3) == 0) ? ACT_FIX : ACT_PREDICT;
                    acc      = int'($urandom_range(0, 2097152)) - 1048576;
                    walk_alt = walk_alt + int'($urandom_range(0, 400000)) - 200000;
                    alt      = walk_alt;
                end
                else
                begin
                    // Noise: any action, full-range or extreme samples, altitude jumps.
                    act = ($urandom_range(0, 1) == 0) ? ACT_PREDICT : ACT_FIX;
                    acc = noise_word();
                    alt = noise_word();
                end
                offer_request(act, acc, alt, arm, 1'b0, '0);
            end
        end

        drain_filter();

        $display("Covered %0d predict and %0d fix requests (%0d disarmed) over %0d settings,",
                 n_predict, n_fix, n_disarmed, PHASES);
        $display("%0d estimates compared, %0d long receiver hold-off(s).", n_checked, n_holds);
        if (n_errors == 0)
            $display("vertical_complementary_filter regression: pass");
        else
            $display("vertical_complementary_filter regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/vcf_pkg.sv
rtl/vcf_front.sv
rtl/vcf_queue.sv
rtl/vcf_back.sv
rtl/vertical_complementary_filter.sv
verif/tb_vertical_complementary_filter.sv
